### design/rthsv_pkg.sv
// shared types, constants and the divider step for the rgb to hsv pixel converter
// no dependencies; used by rthsv_front, rthsv_cell and rgb_to_hsv_pixel

package rthsv_pkg;

    localparam int ChanW    = 8;
    localparam int RemW     = 8;
    localparam int QuotW    = 15;
    localparam int DvdW     = RemW + QuotW;
    localparam int NumW     = 11;
    localparam int NumCells = QuotW;
    localparam int HueW     = 15;

    // 60 degrees in 1/64 degree units, and one full turn
    localparam int HueSector = 3840;
    localparam int HueTurn   = 23040;

    // saturation dividend is 255*delta scaled up so it shares the 15-bit quotient
    localparam int SatShift = QuotW - ChanW;
    localparam int SatScale = 255 * (2 ** SatShift);

    typedef struct packed {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [HueW-1:0]  hue;
        logic [ChanW-1:0] saturation;
        logic [ChanW-1:0] brightness;
    } hsv_t;

    // partial remainder plus a word holding unused dividend bits and quotient bits
    typedef struct packed {
        logic [RemW-1:0]  rem;
        logic [QuotW-1:0] word;
    } div_t;

    typedef struct packed {
        div_t             hue_div;
        div_t             sat_div;
        logic [ChanW-1:0] delta;
        logic [ChanW-1:0] mx;
    } cell_t;

    typedef enum logic [1:0] {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } sector_t;

    // one restoring step; rem < dvs holds before and after
    function automatic div_t div_step(div_t d, logic [ChanW-1:0] dvs);
        logic [RemW:0] t;
        logic [RemW:0] diff;
        logic          qbit;
        div_t          r;
        t    = {d.rem, d.word[QuotW-1]};
        diff = t - {1'b0, dvs};
        qbit = (t >= {1'b0, dvs});
        r.rem  = qbit ? diff[RemW-1:0] : t[RemW-1:0];
        r.word = {d.word[QuotW-2:0], qbit};
        return r;
    endfunction

endpackage

### design/rthsv_front.sv
// front stage: max, min, delta, hue sector numerator and both divider dividends
// depends on rthsv_pkg

module rthsv_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rthsv_pkg::rgb_t      in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rthsv_pkg::cell_t     out_data
);

    logic [rthsv_pkg::ChanW-1:0] r, g, b;
    logic [rthsv_pkg::ChanW-1:0] mx, mn, delta;
    rthsv_pkg::sector_t          sector;
    logic [rthsv_pkg::NumW-1:0]  num;
    logic [rthsv_pkg::DvdW-1:0]  hue_dvd, sat_dvd;
    rthsv_pkg::cell_t            data_next;
    rthsv_pkg::cell_t            data_reg;
    logic                        valid_reg;

    always_comb
    begin
        r = in_data.red;
        g = in_data.green;
        b = in_data.blue;
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        delta = mx - mn;
    end

    always_comb
    begin
        priority if (r == mx)
            sector = rthsv_pkg::SECTOR_RED;
        else if (g == mx)
            sector = rthsv_pkg::SECTOR_GREEN;
        else
            sector = rthsv_pkg::SECTOR_BLUE;
    end

    // numerator kept non-negative: a negative red-sector value gets a full turn of 6*delta
    always_comb
    begin
        unique case (sector)
            rthsv_pkg::SECTOR_RED:
            begin
                if (g >= b)
                    num = rthsv_pkg::NumW'(g) - rthsv_pkg::NumW'(b);
                else
                    num = rthsv_pkg::NumW'(delta) * rthsv_pkg::NumW'(6)
                        - (rthsv_pkg::NumW'(b) - rthsv_pkg::NumW'(g));
            end
            rthsv_pkg::SECTOR_GREEN:
                num = rthsv_pkg::NumW'(b) + (rthsv_pkg::NumW'(delta) << 1)
                    - rthsv_pkg::NumW'(r);
            rthsv_pkg::SECTOR_BLUE:
                num = rthsv_pkg::NumW'(r) + (rthsv_pkg::NumW'(delta) << 2)
                    - rthsv_pkg::NumW'(g);
            default:
                num = '0;
        endcase
    end

    always_comb
    begin
        hue_dvd = rthsv_pkg::DvdW'(num) * rthsv_pkg::DvdW'(rthsv_pkg::HueSector);
        sat_dvd = rthsv_pkg::DvdW'(delta) * rthsv_pkg::DvdW'(rthsv_pkg::SatScale);
        data_next.hue_div.rem  = hue_dvd[rthsv_pkg::DvdW-1:rthsv_pkg::QuotW];
        data_next.hue_div.word = hue_dvd[rthsv_pkg::QuotW-1:0];
        data_next.sat_div.rem  = sat_dvd[rthsv_pkg::DvdW-1:rthsv_pkg::QuotW];
        data_next.sat_div.word = sat_dvd[rthsv_pkg::QuotW-1:0];
        data_next.delta        = delta;
        data_next.mx           = mx;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### design/rthsv_cell.sv
// one divider cell: a restoring step of the hue and the saturation division per stage
// depends on rthsv_pkg

module rthsv_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rthsv_pkg::cell_t     in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rthsv_pkg::cell_t     out_data
);

    rthsv_pkg::cell_t data_next;
    rthsv_pkg::cell_t data_reg;
    logic             valid_reg;

    always_comb
    begin
        data_next         = in_data;
        data_next.hue_div = rthsv_pkg::div_step(in_data.hue_div, in_data.delta);
        data_next.sat_div = rthsv_pkg::div_step(in_data.sat_div, in_data.mx);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### design/rgb_to_hsv_pixel.sv
// top level of the rgb to hsv pixel converter
// depends on rthsv_pkg, rthsv_front and rthsv_cell
//
// usage:
//   input channel rgb (rgb_valid/rgb_ready) carries one pixel of three 8-bit
//   channels; output channel hsv (hsv_valid/hsv_ready) returns hue in 1/64
//   degree (0..23039), saturation floor(255*delta/max) and brightness = max.
//   a transaction happens on a clock edge where valid and ready are both high.
// pipeline:
//   an rgb transaction passes one front stage, then 15 divider cells, each
//   resolving one quotient bit of both divisions, before hsv_valid rises.
//   one pixel per clock while hsv_ready is high; the 16 stages hold up to 16 pixels.
// stalls:
//   each stage accepts when it is empty or its successor accepts, so bubbles
//   are squeezed out; with hsv_ready low the pipeline fills up and rgb_ready
//   falls only once all 16 stages hold pixels.
// reset:
//   rst_n low empties every stage at once; no pixel is in flight afterwards.

module rgb_to_hsv_pixel (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rgb_valid,
    output logic             rgb_ready,
    input  rthsv_pkg::rgb_t  rgb,
    output logic             hsv_valid,
    input  logic             hsv_ready,
    output rthsv_pkg::hsv_t  hsv
);

    logic             stage_valid [rthsv_pkg::NumCells+1];
    logic             stage_ready [rthsv_pkg::NumCells+1];
    rthsv_pkg::cell_t stage_data  [rthsv_pkg::NumCells+1];
    rthsv_pkg::cell_t last;

    rthsv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rgb_valid),
        .in_ready  (rgb_ready),
        .in_data   (rgb),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_data  (stage_data[0])
    );

    for (genvar i = 0; i < rthsv_pkg::NumCells; i++)
    begin : g_cell
        rthsv_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_ready (stage_ready[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    assign last = stage_data[rthsv_pkg::NumCells];
    assign stage_ready[rthsv_pkg::NumCells] = hsv_ready;
    assign hsv_valid = stage_valid[rthsv_pkg::NumCells];

    // gray pixel: the hue division ran on a zero divisor, force hue and saturation to 0
    always_comb
    begin
        hsv.brightness = last.mx;
        if (last.delta == '0)
        begin
            hsv.hue        = '0;
            hsv.saturation = '0;
        end
        else
        begin
            hsv.hue        = last.hue_div.word;
            hsv.saturation = last.sat_div.word[rthsv_pkg::SatShift +: rthsv_pkg::ChanW];
        end
    end

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid |-> (hsv.hue < rthsv_pkg::HueW'(rthsv_pkg::HueTurn)))
        else $error("hue outside one turn");

    a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && (hsv.saturation == '0) |-> (hsv.hue == '0))
        else $error("zero saturation with nonzero hue");

    a_black_sat: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && (hsv.brightness == '0) |-> (hsv.saturation == '0))
        else $error("black pixel with nonzero saturation");

    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_ready |-> rgb_ready)
        else $error("input stalled while output accepts");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && rgb_ready |=> stage_valid[0])
        else $error("accepted pixel missing from front stage");

endmodule

### dv/rgb_to_hsv_pixel_tb.sv
// testbench for rgb_to_hsv_pixel: random and directed pixels with random stalls on both sides
// depends on rthsv_pkg and rgb_to_hsv_pixel; a scoreboard class predicts and checks each result

module rgb_to_hsv_pixel_tb;

    timeunit 1ns;
    timeprecision 1ps;

    class hsv_scoreboard;
        rthsv_pkg::hsv_t expected_pixels[$];
        int              failures;

        function new();
            failures = 0;
        endfunction

        // exact integer hsv of one pixel, hue floored toward minus infinity
        function rthsv_pkg::hsv_t convert_pixel(rthsv_pkg::rgb_t p);
            int              r;
            int              g;
            int              b;
            int              mx;
            int              mn;
            int              delta;
            int              num;
            int              h;
            int              s;
            rthsv_pkg::hsv_t res;
            r = p.red;
            g = p.green;
            b = p.blue;
            mx = (r > g) ? r : g;
            mx = (mx > b) ? mx : b;
            mn = (r < g) ? r : g;
            mn = (mn < b) ? mn : b;
            delta = mx - mn;
            if (delta == 0)
            begin
                h = 0;
                s = 0;
            end
            else
            begin
                s = (255 * delta) / mx;
                if (r == mx)
                    num = g - b;
                else if (g == mx)
                    num = (b - r) + 2 * delta;
                else
                    num = (r - g) + 4 * delta;
                if (num >= 0)
                    h = (rthsv_pkg::HueSector * num) / delta;
                else
                    h = -(((-rthsv_pkg::HueSector * num) + delta - 1) / delta);
                if (h < 0)
                    h = h + rthsv_pkg::HueTurn;
            end
            res.hue        = h[rthsv_pkg::HueW-1:0];
            res.saturation = s[rthsv_pkg::ChanW-1:0];
            res.brightness = mx[rthsv_pkg::ChanW-1:0];
            return res;
        endfunction

        function void note_pixel(rthsv_pkg::rgb_t p);
            expected_pixels.push_back(convert_pixel(p));
        endfunction

        function void check_pixel(rthsv_pkg::hsv_t got);
            rthsv_pkg::hsv_t exp_px;
            if (expected_pixels.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: hue %0d sat %0d val %0d",
                             got.hue, got.saturation, got.brightness);
                return;
            end
            exp_px = expected_pixels.pop_front();
            if (got.hue != exp_px.hue || got.saturation != exp_px.saturation
                || got.brightness != exp_px.brightness)
            begin
                failures++;
                if (failures <= 10)
                    $display({"mismatch: expected hue %0d sat %0d val %0d, ",
                              "got hue %0d sat %0d val %0d"},
                             exp_px.hue, exp_px.saturation, exp_px.brightness,
                             got.hue, got.saturation, got.brightness);
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            rgb_valid = 1'b0;
    logic            rgb_ready;
    rthsv_pkg::rgb_t rgb = '0;
    logic            hsv_valid;
    logic            hsv_ready = 1'b0;
    rthsv_pkg::hsv_t hsv;

    hsv_scoreboard sb = new();

    bit calm = 1'b0;
    bit hold_request = 1'b0;
    bit running = 1'b0;

    rgb_to_hsv_pixel dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rgb_valid (rgb_valid),
        .rgb_ready (rgb_ready),
        .rgb       (rgb),
        .hsv_valid (hsv_valid),
        .hsv_ready (hsv_ready),
        .hsv       (hsv)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic rthsv_pkg::rgb_t make_pixel(int r, int g, int b);
        rthsv_pkg::rgb_t p;
        p.red   = r[rthsv_pkg::ChanW-1:0];
        p.green = g[rthsv_pkg::ChanW-1:0];
        p.blue  = b[rthsv_pkg::ChanW-1:0];
        return p;
    endfunction

    function automatic int clamp_chan(int v);
        if (v < 0)
            return 0;
        if (v > 255)
            return 255;
        return v;
    endfunction

    // mix of uniform colors, ties at the maximum, near-gray, gray and near-black pixels
    function automatic rthsv_pkg::rgb_t random_pixel();
        int              kind;
        int              a;
        int              c;
        int              pos;
        rthsv_pkg::rgb_t p;
        kind = $urandom_range(99);
        if (kind < 55)
            p = make_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
        else if (kind < 70)
        begin
            a = $urandom_range(255);
            c = $urandom_range(a);
            pos = $urandom_range(2);
            if (pos == 0)
                p = make_pixel(a, a, c);
            else if (pos == 1)
                p = make_pixel(a, c, a);
            else
                p = make_pixel(c, a, a);
        end
        else if (kind < 82)
        begin
            a = $urandom_range(255);
            p = make_pixel(clamp_chan(a + $urandom_range(4) - 2),
                           clamp_chan(a + $urandom_range(4) - 2),
                           clamp_chan(a + $urandom_range(4) - 2));
        end
        else if (kind < 92)
        begin
            a = $urandom_range(255);
            p = make_pixel(a, a, a);
        end
        else
            p = make_pixel($urandom_range(3), $urandom_range(3), $urandom_range(3));
        return p;
    endfunction

    task automatic send_pixel(rthsv_pkg::rgb_t p);
        while (!calm && $urandom_range(99) < 22)
        begin
            rgb_valid <= 1'b0;
            @(posedge clk);
        end
        rgb_valid <= 1'b1;
        rgb <= p;
        @(posedge clk);
        while (!rgb_ready)
            @(posedge clk);
        sb.note_pixel(p);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // receiver: checks each transaction, drives ready with random idling and long hold-offs
    initial
    begin
        int hold_left;
        hold_left = 0;
        wait (running);
        forever
        begin
            @(posedge clk);
            if (hsv_valid && hsv_ready)
                sb.check_pixel(hsv);
            if (hold_left > 0)
            begin
                hold_left--;
                hsv_ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = 80;
                hsv_ready <= 1'b0;
            end
            else if (calm)
                hsv_ready <= 1'b1;
            else
                hsv_ready <= ($urandom_range(99) >= 22);
        end
    end

    initial
    begin
        rthsv_pkg::rgb_t directed[$];
        directed.push_back(make_pixel(0, 0, 0));
        directed.push_back(make_pixel(255, 255, 255));
        directed.push_back(make_pixel(128, 128, 128));
        directed.push_back(make_pixel(255, 0, 0));
        directed.push_back(make_pixel(0, 255, 0));
        directed.push_back(make_pixel(0, 0, 255));
        // ties at the maximum: red over green, green over blue, red over blue
        directed.push_back(make_pixel(255, 255, 0));
        directed.push_back(make_pixel(0, 255, 255));
        directed.push_back(make_pixel(255, 0, 255));
        directed.push_back(make_pixel(1, 1, 0));
        directed.push_back(make_pixel(0, 1, 1));
        directed.push_back(make_pixel(1, 0, 1));
        directed.push_back(make_pixel(1, 0, 0));
        directed.push_back(make_pixel(0, 1, 0));
        directed.push_back(make_pixel(0, 0, 1));
        // small negative hue that wraps to just below a full turn
        directed.push_back(make_pixel(255, 0, 1));
        directed.push_back(make_pixel(255, 254, 0));
        directed.push_back(make_pixel(254, 255, 255));
        directed.push_back(make_pixel(255, 255, 254));
        directed.push_back(make_pixel(200, 100, 50));
        directed.push_back(make_pixel(50, 100, 200));
        directed.push_back(make_pixel(100, 200, 50));
        directed.push_back(make_pixel(1, 255, 128));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        running = 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_pixel(directed[i]);

        for (int i = 0; i < 1900; i++)
        begin
            calm = (i >= 500 && i < 800);
            if (i == 1000)
                hold_request = 1'b1;
            if (i == 1400)
            begin
                rgb_valid <= 1'b0;
                @(posedge clk);
                wait_drained();
            end
            send_pixel(random_pixel());
        end
        rgb_valid <= 1'b0;
        calm = 1'b0;

        wait_drained();
        repeat (40) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("rgb_to_hsv_pixel test passed");
        else
            $display("rgb_to_hsv_pixel test failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("rgb_to_hsv_pixel test failed");
        $finish;
    end

endmodule
